### rtl/lpht_pkg.sv
package lpht_pkg;

    // Field widths of the channels
    localparam int CMD_W   = 2;
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 7;
    localparam int CAP_W   = 7;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

    // Slot state codes
    localparam logic [1:0] SLOT_EMPTY    = 2'd0;
    localparam logic [1:0] SLOT_OCCUPIED = 2'd1;
    localparam logic [1:0] SLOT_DELETED  = 2'd2;

    // Hash, load limit and reset capacity constants
    localparam logic [KEY_W-1:0] DJB_START = 64'd5381;
    localparam int               LOAD_NUM  = 7;
    localparam int               LOAD_DEN  = 10;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd20;

    // Remainder unit: bits of hash taken per cycle
    localparam int MOD_RADIX  = 4;
    localparam int MOD_CYCLES = KEY_W / MOD_RADIX;
    localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic              found;
        logic [VAL_W-1:0]  data_out;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
    } t_out;

    typedef struct packed {
        logic [1:0]       state;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_slot;

    typedef enum logic [1:0] {
        H_IDLE,
        H_BYTE,
        H_MOD,
        H_DONE
    } t_hsh_state;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_WRITE,
        S_DONE
    } t_state;

endpackage

### rtl/linear_probe_hash_table_top.sv
// Open-addressing key/value table with linear probing and tombstones, held in one
// slot memory with a registered read. An operation hashes the key byte-serially,
// takes the remainder by the capacity (4 hash bits per cycle), walks the probe chain
// one slot at a time through the single memory read port, writes the slot where the
// command needs it and posts the result. The key length and the probe length set how
// long an operation takes. After reset and after every capacity write the block clears
// the slot memory, one slot a cycle across all TABLE_DEPTH slots, and accepts no
// operation until the clear is done. A finished result waits in the output register
// while the next operation is taken in.
module linear_probe_hash_table_top #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BYTES   = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  lpht_pkg::t_in               i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output lpht_pkg::t_out              o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lpht_pkg::CAP_W-1:0]  i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = CW + 8;

    lpht_pkg::t_state r_state, n_state;

    logic [lpht_pkg::CAP_W-1:0] r_cap;
    logic [lpht_pkg::CNT_W-1:0] r_count;
    logic [lpht_pkg::CMD_W-1:0] r_cmd;
    logic [lpht_pkg::KEY_W-1:0] r_key;
    logic [lpht_pkg::VAL_W-1:0] r_val;
    logic [AW-1:0]              r_clr;
    logic [AW-1:0]              r_pos;
    logic [CW-1:0]              r_steps;
    logic                       r_free_v;
    logic [AW-1:0]              r_free;
    logic                       r_hit_v;
    logic [AW-1:0]              r_hit;
    logic [lpht_pkg::VAL_W-1:0] r_hit_val;
    lpht_pkg::t_out             r_res, n_res;
    lpht_pkg::t_out             r_out;
    logic                       r_out_valid;
    logic [lpht_pkg::CNT_W-1:0] n_count;

    logic [CW-1:0]              eff_cap;
    logic [lpht_pkg::KEY_W-1:0] norm_key;
    logic                       hash_done;
    logic [AW-1:0]              home;
    logic                       in_xfer, out_xfer, cfg_xfer;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    lpht_pkg::t_slot            wr_data;
    logic [AW-1:0]              rd_addr;
    lpht_pkg::t_slot            rd_data;
    logic [CW-1:0]              pos_inc;
    logic [AW-1:0]              pos_next;
    logic                       hit_now, step_last, probe_end, at_limit;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = r_out_valid && i_out_ready;
    assign cfg_xfer = i_cfg_valid && o_cfg_ready;

    // Hold off operations while a capacity write is offered
    assign o_in_ready  = (r_state == lpht_pkg::S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Clamp capacity into 1..TABLE_DEPTH
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CW'(1);
        end else if (32'(r_cap) > 32'(TABLE_DEPTH)) begin
            eff_cap = CW'(TABLE_DEPTH);
        end else begin
            eff_cap = CW'(r_cap);
        end
    end

    // Keep bytes up to the first zero byte and within KEY_BYTES
    always_comb begin
        logic keep;
        keep     = 1'b1;
        norm_key = '0;
        for (int j = 0; j < 8; j++) begin
            keep = keep && (j < KEY_BYTES) && (i_in_data.key[8*j +: 8] != 8'd0);
            if (keep) begin
                norm_key[8*j +: 8] = i_in_data.key[8*j +: 8];
            end
        end
    end

    lpht_hash #(
        .AW (AW),
        .CW (CW)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_xfer),
        .i_key   (norm_key),
        .i_cap   (eff_cap),
        .o_done  (hash_done),
        .o_home  (home)
    );

    lpht_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Probe step decode
    always_comb begin
        pos_inc   = CW'(r_pos) + 1'b1;
        pos_next  = (pos_inc == eff_cap) ? '0 : AW'(pos_inc);
        hit_now   = (rd_data.state == lpht_pkg::SLOT_OCCUPIED) && (rd_data.key == r_key);
        step_last = ((r_steps + 1'b1) == eff_cap);
        probe_end = (rd_data.state == lpht_pkg::SLOT_EMPTY) || hit_now || step_last;
        at_limit  = (LW'(r_count) * LW'(lpht_pkg::LOAD_DEN))
                    >= (LW'(eff_cap) * LW'(lpht_pkg::LOAD_NUM));
        rd_addr   = (r_state == lpht_pkg::S_CHECK) ? pos_next : r_pos;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lpht_pkg::S_CLEAR: begin
                if (r_clr == AW'(TABLE_DEPTH - 1)) n_state = lpht_pkg::S_IDLE;
            end
            lpht_pkg::S_IDLE:  if (in_xfer) n_state = lpht_pkg::S_HASH;
            lpht_pkg::S_HASH:  if (hash_done) n_state = lpht_pkg::S_READ;
            lpht_pkg::S_READ:  n_state = lpht_pkg::S_CHECK;
            lpht_pkg::S_CHECK: if (probe_end) n_state = lpht_pkg::S_WRITE;
            lpht_pkg::S_WRITE: n_state = lpht_pkg::S_DONE;
            lpht_pkg::S_DONE:  if (!r_out_valid || i_out_ready) n_state = lpht_pkg::S_IDLE;
            default:           n_state = lpht_pkg::S_CLEAR;
        endcase
        if (cfg_xfer) n_state = lpht_pkg::S_CLEAR;
    end

    // Memory writes and the result of the operation
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_hit;
        wr_data = '{state: lpht_pkg::SLOT_OCCUPIED, key: r_key, value: r_val};
        n_count = r_count;
        n_res   = '{found: 1'b0, data_out: '0, status: lpht_pkg::STAT_OK, count: r_count};
        case (r_state)
            lpht_pkg::S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = '{state: lpht_pkg::SLOT_EMPTY, key: '0, value: '0};
            end
            lpht_pkg::S_WRITE: begin
                case (r_cmd)
                    lpht_pkg::CMD_PUT: begin
                        if (r_hit_v) begin
                            // update in place
                            wr_en       = 1'b1;
                            n_res.found = 1'b1;
                        end else if (at_limit || !r_free_v) begin
                            n_res.status = lpht_pkg::STAT_FULL;
                        end else begin
                            // insert into first free slot on the chain
                            wr_en   = 1'b1;
                            wr_addr = r_free;
                            n_count = r_count + 1'b1;
                        end
                    end
                    lpht_pkg::CMD_GET, lpht_pkg::CMD_DEL: begin
                        if (r_hit_v) begin
                            n_res.found    = 1'b1;
                            n_res.data_out = r_hit_val;
                            if (r_cmd == lpht_pkg::CMD_DEL) begin
                                // leave a tombstone
                                wr_en         = 1'b1;
                                wr_data.state = lpht_pkg::SLOT_DELETED;
                                wr_data.value = r_hit_val;
                                if (r_count != '0) n_count = r_count - 1'b1;
                            end
                        end else begin
                            n_res.status = lpht_pkg::STAT_NOTFOUND;
                        end
                    end
                    default: begin
                        n_res.status = lpht_pkg::STAT_NOTFOUND;
                    end
                endcase
                n_res.count = n_count;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpht_pkg::S_CLEAR;
            r_cap       <= lpht_pkg::CAP_RESET;
            r_count     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // hold result until transferred
            if (r_state == lpht_pkg::S_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_xfer) begin
                r_cap   <= i_cfg_data;
                r_count <= '0;
                r_clr   <= '0;
            end else begin
                if (r_state == lpht_pkg::S_CLEAR) r_clr <= r_clr + 1'b1;
                if (r_state == lpht_pkg::S_WRITE) r_count <= n_count;
            end
        end
    end

    // Operation and probe registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd    <= i_in_data.cmd;
            r_key    <= norm_key;
            r_val    <= i_in_data.value;
            r_free_v <= 1'b0;
            r_hit_v  <= 1'b0;
        end
        if (r_state == lpht_pkg::S_HASH && hash_done) begin
            r_pos   <= home;
            r_steps <= '0;
        end
        if (r_state == lpht_pkg::S_CHECK) begin
            if (!r_free_v && rd_data.state != lpht_pkg::SLOT_OCCUPIED) begin
                r_free_v <= 1'b1;
                r_free   <= r_pos;
            end
            if (hit_now) begin
                r_hit_v   <= 1'b1;
                r_hit     <= r_pos;
                r_hit_val <= rd_data.value;
            end
            if (!probe_end) begin
                r_pos   <= pos_next;
                r_steps <= r_steps + 1'b1;
            end
        end
        if (r_state == lpht_pkg::S_WRITE) r_res <= n_res;
        if (r_state == lpht_pkg::S_DONE && (!r_out_valid || i_out_ready)) r_out <= r_res;
    end

endmodule

### rtl/lpht_mem.sv
module lpht_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  lpht_pkg::t_slot      i_wr_data,
    input  logic [AW-1:0]        i_rd_addr,
    output lpht_pkg::t_slot      o_rd_data
);

    lpht_pkg::t_slot r_mem [DEPTH];
    lpht_pkg::t_slot r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/lpht_hash.sv
module lpht_hash #(
    parameter int AW = 6,
    parameter int CW = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lpht_pkg::KEY_W-1:0]  i_key,
    input  logic [CW-1:0]               i_cap,
    output logic                        o_done,
    output logic [AW-1:0]               o_home
);

    lpht_pkg::t_hsh_state r_state, n_state;
    logic [lpht_pkg::KEY_W-1:0]   r_raw;
    logic [lpht_pkg::KEY_W-1:0]   r_h;
    logic [CW-1:0]                r_rem;
    logic [lpht_pkg::MOD_CNT_W-1:0] r_cnt;
    logic [CW-1:0]                n_rem;
    logic                         byte_end;

    assign byte_end = (r_raw[7:0] == 8'd0);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lpht_pkg::H_IDLE: if (i_start) n_state = lpht_pkg::H_BYTE;
            lpht_pkg::H_BYTE: if (byte_end) n_state = lpht_pkg::H_MOD;
            lpht_pkg::H_MOD: begin
                if (r_cnt == lpht_pkg::MOD_CNT_W'(lpht_pkg::MOD_CYCLES - 1)) begin
                    n_state = lpht_pkg::H_DONE;
                end
            end
            lpht_pkg::H_DONE: n_state = lpht_pkg::H_IDLE;
            default: n_state = lpht_pkg::H_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_done = (r_state == lpht_pkg::H_DONE);
        o_home = AW'(r_rem);
    end

    // Fold MOD_RADIX hash bits, most significant first, into the remainder
    always_comb begin
        logic [CW:0] t;
        t = {1'b0, r_rem};
        for (int j = 0; j < lpht_pkg::MOD_RADIX; j++) begin
            t = {t[CW-1:0], r_h[lpht_pkg::KEY_W-1-j]};
            if (t >= {1'b0, i_cap}) begin
                t = t - {1'b0, i_cap};
            end
        end
        n_rem = t[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpht_pkg::H_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Byte loop: h = h*33 + byte, then the remainder walk
    always_ff @(posedge i_clk) begin
        case (r_state)
            lpht_pkg::H_IDLE: begin
                r_raw <= i_key;
                r_h   <= lpht_pkg::DJB_START;
                r_rem <= '0;
                r_cnt <= '0;
            end
            lpht_pkg::H_BYTE: begin
                if (!byte_end) begin
                    r_h   <= (r_h << 5) + r_h + {56'd0, r_raw[7:0]};
                    r_raw <= {8'd0, r_raw[lpht_pkg::KEY_W-1:8]};
                end
            end
            lpht_pkg::H_MOD: begin
                r_rem <= n_rem;
                r_h   <= r_h << lpht_pkg::MOD_RADIX;
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule

### rtl/lpht_checker.sv
module lpht_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            o_in_ready,
    input  logic            o_out_valid,
    input  logic            i_out_ready,
    input  lpht_pkg::t_out  o_out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result changed while stalled");

    // Drop ready after an operation is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second operation taken while busy");

    // A found key never reports an error status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.found |-> o_out_data.status == lpht_pkg::STAT_OK)
        else $error("found with error status");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out_data.count) <= 32'(TABLE_DEPTH))
        else $error("count above table depth");

endmodule

bind linear_probe_hash_table_top lpht_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_lpht_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
